FILE: rtl/core/keyframe_pose_interpolator_core_assert.svh
// Assertion macros for the keyframe pose interpolator core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef KEYFRAME_POSE_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_POSE_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication under reset
`define KPI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpi check failed");

// next-cycle implication under reset
`define KPI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpi check failed");

`endif

FILE: rtl/core/kpi_pkg.sv
// Shared types and constants of the keyframe pose interpolator core.
// No dependencies; used by kpi_div, the top level and the testbench.
package kpi_pkg;

	localparam int NUM_CH = 10;
	localparam logic [3:0] CH_TIME = 4'd10;
	localparam logic [3:0] LAST_CH = 4'd9;
	localparam logic [3:0] SCALE_FIRST = 4'd7;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_QUERY_ABS = 2'd1;
	localparam logic [1:0] CMD_QUERY_ADV = 2'd2;

	localparam logic [1:0] STAT_VALID = 2'd0;
	localparam logic [1:0] STAT_NULL = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic [1:0] REG_ALLOC = 2'd0;
	localparam logic [1:0] REG_FILLED = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_IGNORE = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_WRAP, S_SCAN, S_RDA, S_RDB, S_MUL, S_PROD, S_DGO, S_DIV, S_OUT, S_CONST
	} state_t;

	typedef struct packed {
		logic start;
		logic [31:0] rem_init;
		logic [31:0] dividend_lo;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_res_t;

endpackage

FILE: rtl/core/kpi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/kpi_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on kpi_pkg for the request and result structs.
module kpi_div (
	input  logic clk,
	input  logic arst_n,
	input  kpi_pkg::div_req_t req,
	output kpi_pkg::div_res_t res
);

	localparam logic [5:0] STEPS = 6'd32;

	logic [5:0] cnt_q;
	logic done_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [32:0] r;
	logic [32:0] diff;
	logic ge;

	assign r = {rem_q, quo_q[31]};
	assign diff = r - {1'b0, div_q};
	assign ge = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
			done_q <= (cnt_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			quo_q <= req.dividend_lo;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[31:0] : r[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem = rem_q;

endmodule

FILE: rtl/core/keyframe_pose_interpolator_core.sv
// Keyframe pose interpolator: keyframe tables in RAM, scan, per-channel lerp.
// Depends on kpi_pkg, kpi_ram, kpi_div and the assertion macro header.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      cmd, frame_index, channel, value, time_value
//  m_*       out  tvalid/tready      out_channel, out_value; tlast; tuser = status
//  apb       in   psel/penable       four registers at 4*i
//
// A query with no frames or the null pose emits constants; a playback or copied
// keyframe reads and emits each channel in turn. Interpolation: wrap division
// when the time passes a nonzero loop period, one keyframe time per cycle in
// the scan, then per channel a multiply and the 32-step serial divider.
// Reset clears control, registers, cursor and accumulated time; RAMs are not
// cleared. A stalled output holds the sequencer; one result register decouples.
module keyframe_pose_interpolator_core #(
	parameter int MAX_FRAMES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [79:0] s_tdata,   // cmd[1:0] frame_index[7:2] channel[11:8] value[43:12] time_value[75:44]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata,   // out_channel[3:0] out_value[35:4]
	output logic m_tlast,
	output logic [1:0] m_tuser,    // status[1:0]
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	`include "keyframe_pose_interpolator_core_assert.svh"

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int AW = $clog2(MAX_FRAMES * kpi_pkg::NUM_CH);

	// input fields
	logic [1:0] cmd;
	logic [5:0] frame_index;
	logic [3:0] channel;
	logic signed [31:0] value;
	logic [31:0] time_value;
	assign cmd = s_tdata[1:0];
	assign frame_index = s_tdata[7:2];
	assign channel = s_tdata[11:8];
	assign value = s_tdata[43:12];
	assign time_value = s_tdata[75:44];

	// configuration
	logic [6:0] frames_allocated_q;
	logic [6:0] frames_filled_q;
	logic [31:0] loop_period_q;
	logic ignore_time_q;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_allocated_q <= '0;
			frames_filled_q <= '0;
			loop_period_q <= '0;
			ignore_time_q <= 1'b0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				kpi_pkg::REG_ALLOC: frames_allocated_q <= pwdata[6:0];
				kpi_pkg::REG_FILLED: frames_filled_q <= pwdata[6:0];
				kpi_pkg::REG_PERIOD: loop_period_q <= pwdata;
				kpi_pkg::REG_IGNORE: ignore_time_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			kpi_pkg::REG_ALLOC: prdata = {25'd0, frames_allocated_q};
			kpi_pkg::REG_FILLED: prdata = {25'd0, frames_filled_q};
			kpi_pkg::REG_PERIOD: prdata = loop_period_q;
			kpi_pkg::REG_IGNORE: prdata = {31'd0, ignore_time_q};
			default: prdata = '0;
		endcase
	end

	logic [6:0] alloc;
	assign alloc = (int'(frames_allocated_q) > MAX_FRAMES) ? 7'(MAX_FRAMES)
		: frames_allocated_q;

	// state
	kpi_pkg::state_t state_q, state_d;
	logic [FW-1:0] cursor_q;
	logic [31:0] acc_q;
	logic [31:0] t_q;
	logic [1:0] status_q;
	logic [3:0] j_q;
	logic copy_q;
	logic [FW-1:0] prev_q;
	logic [FW-1:0] next_q;
	logic [FW:0] rd_q;
	logic vld_s1;
	logic [FW-1:0] idx_s1;
	logic [31:0] tprev_q;
	logic [31:0] span_q;
	logic [31:0] elapsed_q;
	logic signed [31:0] a_q;
	logic neg_q;
	logic [31:0] mag_q;
	logic [63:0] prod_q;

	logic out_valid_q;
	logic [3:0] out_ch_q;
	logic [31:0] out_val_q;
	logic out_last_q;
	logic [1:0] out_stat_q;

	// memories
	logic pose_we, time_we;
	logic [AW-1:0] pose_waddr, pose_raddr;
	logic [FW-1:0] time_waddr, time_raddr;
	logic [31:0] pose_rdata, time_rdata;

	kpi_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES * kpi_pkg::NUM_CH)) u_pose_ram (
		.clk(clk), .we(pose_we), .waddr(pose_waddr), .wdata(value),
		.raddr(pose_raddr), .rdata(pose_rdata)
	);

	kpi_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_time_ram (
		.clk(clk), .we(time_we), .waddr(time_waddr), .wdata(value),
		.raddr(time_raddr), .rdata(time_rdata)
	);

	kpi_pkg::div_req_t div_req;
	kpi_pkg::div_res_t div_res;

	kpi_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .res(div_res));

	// query decode
	logic accept, is_query, play_mode, need_wrap;
	logic [31:0] acc_sum, tq;
	logic [FW-1:0] cur_sel;
	logic slot_free;
	logic hit, scan_end;
	logic [32:0] d;
	logic [31:0] lerp_val, out_val_d;

	assign accept = s_tvalid && s_tready;
	assign is_query = (cmd == kpi_pkg::CMD_QUERY_ABS) || (cmd == kpi_pkg::CMD_QUERY_ADV);
	assign acc_sum = acc_q + time_value;
	assign tq = (cmd == kpi_pkg::CMD_QUERY_ADV) ? acc_sum : time_value;
	assign play_mode = ignore_time_q || (alloc == 7'd1);
	assign need_wrap = (tq > loop_period_q) && (loop_period_q != '0);
	assign cur_sel = (int'(cursor_q) + 1 >= int'(alloc)) ? '0 : cursor_q;
	assign slot_free = !out_valid_q || m_tready;
	assign hit = (tprev_q <= t_q) && (t_q <= time_rdata);
	assign scan_end = vld_s1 && (idx_s1 != '0) && (hit || int'(idx_s1) == int'(alloc) - 1);
	assign d = {pose_rdata[31], pose_rdata} - {a_q[31], a_q};
	assign lerp_val = neg_q ? (a_q - div_res.quot) : (a_q + div_res.quot);
	assign out_val_d = copy_q ? a_q : lerp_val;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kpi_pkg::S_IDLE: begin
				if (accept && is_query) begin
					if (frames_filled_q == '0 || alloc == '0) begin
						state_d = kpi_pkg::S_CONST;
					end else if (play_mode) begin
						state_d = kpi_pkg::S_RDA;
					end else if (need_wrap) begin
						state_d = kpi_pkg::S_WRAP;
					end else begin
						state_d = kpi_pkg::S_SCAN;
					end
				end
			end
			kpi_pkg::S_WRAP: if (div_res.done) state_d = kpi_pkg::S_SCAN;
			kpi_pkg::S_SCAN: if (scan_end) state_d = kpi_pkg::S_RDA;
			kpi_pkg::S_RDA: state_d = kpi_pkg::S_RDB;
			kpi_pkg::S_RDB: state_d = copy_q ? kpi_pkg::S_OUT : kpi_pkg::S_MUL;
			kpi_pkg::S_MUL: state_d = kpi_pkg::S_PROD;
			kpi_pkg::S_PROD: state_d = kpi_pkg::S_DGO;
			kpi_pkg::S_DGO: state_d = kpi_pkg::S_DIV;
			kpi_pkg::S_DIV: if (div_res.done) state_d = kpi_pkg::S_OUT;
			kpi_pkg::S_OUT: begin
				if (slot_free) begin
					state_d = (j_q == kpi_pkg::LAST_CH) ? kpi_pkg::S_IDLE : kpi_pkg::S_RDA;
				end
			end
			kpi_pkg::S_CONST: begin
				if (slot_free && j_q == kpi_pkg::LAST_CH) state_d = kpi_pkg::S_IDLE;
			end
			default: state_d = kpi_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == kpi_pkg::S_IDLE);
		pose_we = accept && (cmd == kpi_pkg::CMD_WRITE)
			&& (int'(frame_index) < MAX_FRAMES) && (int'(channel) < kpi_pkg::NUM_CH);
		time_we = accept && (cmd == kpi_pkg::CMD_WRITE)
			&& (int'(frame_index) < MAX_FRAMES) && (channel == kpi_pkg::CH_TIME);
		pose_waddr = AW'(int'(frame_index) * kpi_pkg::NUM_CH + int'(channel));
		time_waddr = FW'(frame_index);
		time_raddr = rd_q[FW-1:0];
		pose_raddr = (state_q == kpi_pkg::S_RDA)
			? AW'(int'(prev_q) * kpi_pkg::NUM_CH + int'(j_q))
			: AW'(int'(next_q) * kpi_pkg::NUM_CH + int'(j_q));
		div_req.start = 1'b0;
		div_req.rem_init = prod_q[63:32];
		div_req.dividend_lo = prod_q[31:0];
		div_req.divisor = span_q;
		case (state_q)
			kpi_pkg::S_IDLE: begin
				div_req.start = accept && is_query && need_wrap
					&& (frames_filled_q != '0) && (alloc != '0) && !play_mode;
				div_req.rem_init = '0;
				div_req.dividend_lo = tq;
				div_req.divisor = loop_period_q;
			end
			kpi_pkg::S_DGO: div_req.start = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpi_pkg::S_IDLE;
			cursor_q <= '0;
			acc_q <= '0;
			j_q <= '0;
			rd_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == kpi_pkg::S_OUT || state_q == kpi_pkg::S_CONST) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				kpi_pkg::S_IDLE: begin
					j_q <= '0;
					rd_q <= '0;
					vld_s1 <= 1'b0;
					if (accept && cmd == kpi_pkg::CMD_QUERY_ADV) acc_q <= acc_sum;
					if (accept && is_query && frames_filled_q != '0 && alloc != '0
						&& play_mode) begin
						cursor_q <= (int'(cur_sel) + 1 >= int'(frames_filled_q))
							? '0 : cur_sel + 1'b1;
					end
				end
				kpi_pkg::S_SCAN: begin
					rd_q <= rd_q + 1'b1;
					vld_s1 <= 1'b1;
				end
				kpi_pkg::S_OUT, kpi_pkg::S_CONST: begin
					if (slot_free) begin
						j_q <= j_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[FW-1:0];
		case (state_q)
			kpi_pkg::S_IDLE: begin
				t_q <= (tq > loop_period_q) ? '0 : tq;
				if (frames_filled_q == '0) begin
					status_q <= kpi_pkg::STAT_EMPTY;
				end else if (alloc == '0) begin
					status_q <= kpi_pkg::STAT_NULL;
				end else begin
					status_q <= kpi_pkg::STAT_VALID;
				end
				copy_q <= play_mode;
				prev_q <= cur_sel;
				next_q <= cur_sel;
			end
			kpi_pkg::S_WRAP: if (div_res.done) t_q <= div_res.rem;
			kpi_pkg::S_SCAN: begin
				if (vld_s1) begin
					tprev_q <= time_rdata;
					if (idx_s1 != '0 && hit) begin
						prev_q <= idx_s1 - 1'b1;
						next_q <= idx_s1;
						copy_q <= 1'b0;
						elapsed_q <= t_q - tprev_q;
						span_q <= (time_rdata == tprev_q) ? 32'd1 : time_rdata - tprev_q;
					end else begin
						prev_q <= '0;
						next_q <= '0;
						copy_q <= 1'b1;
					end
				end
			end
			kpi_pkg::S_RDB: a_q <= pose_rdata;
			kpi_pkg::S_MUL: begin
				neg_q <= d[32];
				mag_q <= d[32] ? 32'(-d) : d[31:0];
			end
			kpi_pkg::S_DGO: ;
			default: ;
		endcase
		// product of magnitude and elapsed time, registered before the divider
		prod_q <= {32'd0, mag_q} * {32'd0, elapsed_q};
		if ((state_q == kpi_pkg::S_OUT || state_q == kpi_pkg::S_CONST) && slot_free) begin
			out_ch_q <= j_q;
			out_last_q <= (j_q == kpi_pkg::LAST_CH);
			out_stat_q <= status_q;
			if (state_q == kpi_pkg::S_OUT) begin
				out_val_q <= out_val_d;
			end else begin
				out_val_q <= (status_q == kpi_pkg::STAT_NULL && j_q >= kpi_pkg::SCALE_FIRST)
					? kpi_pkg::ONE_Q16 : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, out_val_q, out_ch_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_stat_q;

	`KPI_ASSERT_IMP(a_div_done_owner, div_res.done,
		state_q == kpi_pkg::S_WRAP || state_q == kpi_pkg::S_DIV)
	`KPI_ASSERT_IMP(a_chan_range, state_q != kpi_pkg::S_IDLE, j_q <= kpi_pkg::LAST_CH)
	`KPI_ASSERT_IMP(a_quot_bound, state_q == kpi_pkg::S_OUT && !copy_q,
		div_res.quot <= mag_q)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for keyframe_pose_interpolator_core: stream items in,
// pose results out, registers set over APB. Expected poses come from an internal
// predictor or from typed table rows; depends on kpi_pkg and the core RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES = 64;
	localparam int LOADED = 8;

	typedef struct {
		logic [3:0] ch;
		logic [31:0] val;
		logic last;
		logic [1:0] stat;
	} pose_res_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [1:0] cmd;     // register index for ROW_CFG
		logic [5:0] fi;
		logic [3:0] ch;
		logic [31:0] value;  // register data for ROW_CFG
		logic [31:0] tv;
		logic typed;
		logic [1:0] tstat;
		logic [31:0] tval;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [79:0] s_tdata = '0;  // cmd, frame_index, channel, value, time_value
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;       // out_channel, out_value
	logic m_tlast;
	logic [1:0] m_tuser;        // status
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	keyframe_pose_interpolator_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	logic [31:0] pose_mem [FRAMES*kpi_pkg::NUM_CH];
	logic [31:0] stamp_mem [FRAMES];
	logic [5:0] cursor;
	logic [31:0] acc_time;
	logic [6:0] alloc_reg, filled_reg;
	logic [31:0] period_reg;
	logic ignore_reg;

	pose_res_t pending_poses[$];
	int errors = 0;
	bit send_burst = 0, recv_burst = 0, hold_for_empty = 0;

	function automatic logic [31:0] lerp_channel(logic [31:0] a, logic [31:0] b,
			logic [31:0] el, logic [31:0] span);
		longint pa, pb, d;
		bit [63:0] mag, q;
		pa = longint'(signed'(a));
		pb = longint'(signed'(b));
		d = pb - pa;
		mag = (d < 0) ? -d : d;
		q = (mag * {32'd0, el}) / {32'd0, span};
		return (d < 0) ? 32'(pa - longint'(q)) : 32'(pa + longint'(q));
	endfunction

	task automatic queue_pose(logic [31:0] vals [kpi_pkg::NUM_CH], logic [1:0] stat);
		pose_res_t r;
		for (int j = 0; j < kpi_pkg::NUM_CH; j++) begin
			r.ch = 4'(j);
			r.val = vals[j];
			r.last = (j == kpi_pkg::NUM_CH - 1);
			r.stat = stat;
			pending_poses.push_back(r);
		end
	endtask

	task automatic interpolate_item(logic [1:0] cmd, logic [5:0] fi, logic [3:0] ch,
			logic [31:0] value, logic [31:0] tv, bit push);
		logic [31:0] vals [kpi_pkg::NUM_CH];
		logic [31:0] t, span, el;
		int alloc, f, prv, nxt;
		logic [1:0] stat;
		stat = kpi_pkg::STAT_VALID;
		if (cmd == kpi_pkg::CMD_WRITE) begin
			if (ch < kpi_pkg::CH_TIME) pose_mem[fi*kpi_pkg::NUM_CH + ch] = value;
			else if (ch == kpi_pkg::CH_TIME) stamp_mem[fi] = value;
			return;
		end
		if (cmd != kpi_pkg::CMD_QUERY_ABS && cmd != kpi_pkg::CMD_QUERY_ADV) return;
		t = tv;
		if (cmd == kpi_pkg::CMD_QUERY_ADV) begin
			acc_time = acc_time + tv;
			t = acc_time;
		end
		alloc = (alloc_reg > FRAMES) ? FRAMES : alloc_reg;
		if (filled_reg == 0) begin
			foreach (vals[j]) vals[j] = '0;
			stat = kpi_pkg::STAT_EMPTY;
		end else if (alloc == 0) begin
			foreach (vals[j]) vals[j] = (j >= kpi_pkg::SCALE_FIRST) ? kpi_pkg::ONE_Q16 : '0;
			stat = kpi_pkg::STAT_NULL;
		end else if (ignore_reg || alloc == 1) begin
			if (int'(cursor) + 1 >= alloc) cursor = 0;
			f = cursor;
			cursor = 6'(f + 1);
			foreach (vals[j]) vals[j] = pose_mem[f*kpi_pkg::NUM_CH + j];
			if (f + 1 >= filled_reg) cursor = 0;
		end else begin
			prv = 0;
			nxt = 0;
			if (t > period_reg) t = (period_reg == 0) ? '0 : t % period_reg;
			for (int i = 0; i + 1 < alloc; i++) begin
				if (stamp_mem[i] <= t && t <= stamp_mem[i+1]) begin
					prv = i;
					nxt = i + 1;
					break;
				end
			end
			if (prv == nxt) begin
				foreach (vals[j]) vals[j] = pose_mem[prv*kpi_pkg::NUM_CH + j];
			end else begin
				span = stamp_mem[nxt] - stamp_mem[prv];
				el = t - stamp_mem[prv];
				if (span == 0) span = 1;
				foreach (vals[j])
					vals[j] = lerp_channel(pose_mem[prv*kpi_pkg::NUM_CH + j],
						pose_mem[nxt*kpi_pkg::NUM_CH + j], el, span);
			end
		end
		if (push) queue_pose(vals, stat);
	endtask

	task automatic send_item(logic [1:0] cmd, logic [5:0] fi, logic [3:0] ch,
			logic [31:0] value, logic [31:0] tv, bit push);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (hold_for_empty) begin
			@(negedge clk) s_tvalid <= 0;
			while (pending_poses.size() != 0) @(negedge clk);
		end else if (gap > 0) begin
			@(negedge clk) s_tvalid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= {4'd0, tv, value, ch, fi, cmd};
		do @(posedge clk); while (!s_tready);
		interpolate_item(cmd, fi, ch, value, tv, push);
	endtask

	// drain all results, then let a trailing write settle
	task automatic wait_idle();
		@(negedge clk) s_tvalid <= 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		wait_idle();
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk) penable <= 1;
		do @(posedge clk); while (!pready);
		case (idx)
			kpi_pkg::REG_ALLOC: alloc_reg = data[6:0];
			kpi_pkg::REG_FILLED: filled_reg = data[6:0];
			kpi_pkg::REG_PERIOD: period_reg = data;
			kpi_pkg::REG_IGNORE: ignore_reg = data[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	// result side: draw a stall per item, check at the accepting edge
	initial begin
		int n;
		pose_res_t e;
		@(posedge arst_n);
		forever begin
			n = recv_burst ? 0 : $urandom_range(0, 14);
			if (n > 0) begin
				@(negedge clk) m_tready <= 0;
				repeat (n - 1) @(negedge clk);
				@(negedge clk) m_tready <= 1;
			end else if (!m_tready) begin
				@(negedge clk) m_tready <= 1;
			end
			do @(posedge clk); while (!(m_tvalid && m_tready));
			if (pending_poses.size() == 0) begin
				$error("unexpected result: out_channel %0d out_value %h", m_tdata[3:0],
					m_tdata[35:4]);
				errors++;
			end else begin
				e = pending_poses.pop_front();
				if (m_tdata[3:0] !== e.ch) begin
					$error("out_channel expected %0d actual %0d", e.ch, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[35:4] !== e.val) begin
					$error("out_value expected %h actual %h", e.val, m_tdata[35:4]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last expected %0b actual %0b", e.last, m_tlast);
					errors++;
				end
				if (m_tuser !== e.stat) begin
					$error("status expected %0d actual %0d", e.stat, m_tuser);
					errors++;
				end
			end
		end
	end

	row_t rows [] = '{
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd0,
			1, kpi_pkg::STAT_EMPTY, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ADV, 6'd0, 4'd0, 32'd0, 32'hFFFF_FFFF,
			1, kpi_pkg::STAT_EMPTY, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ADV, 6'd0, 4'd0, 32'd0, 32'd1,
			1, kpi_pkg::STAT_EMPTY, 32'd0},
		'{ROW_ITEM, 2'd3, 6'd63, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_WRITE, 6'd0, 4'd15, 32'h1234_5678, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_WRITE, 6'd63, 4'd11, 32'h8765_4321, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_FILLED, 6'd0, 4'd0, 32'd5, 32'd0, 0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd700,
			1, kpi_pkg::STAT_NULL, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_ALLOC, 6'd0, 4'd0, 32'd8, 32'd0, 0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'hFFFF_FFFF,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_PERIOD, 6'd0, 4'd0, 32'hFFFF_FFFF, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'hFFFF_FFFF,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd500,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd1500,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd2000,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_PERIOD, 6'd0, 4'd0, 32'd3000, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ADV, 6'd0, 4'd0, 32'd0, 32'd3700,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd3000,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_IGNORE, 6'd0, 4'd0, 32'd1, 32'd0, 0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ADV, 6'd0, 4'd0, 32'd0, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd0,
			0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_IGNORE, 6'd0, 4'd0, 32'd0, 32'd0, 0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_CFG, kpi_pkg::REG_ALLOC, 6'd0, 4'd0, 32'd1, 32'd0, 0, kpi_pkg::STAT_VALID, 32'd0},
		'{ROW_ITEM, kpi_pkg::CMD_QUERY_ABS, 6'd0, 4'd0, 32'd0, 32'd900,
			0, kpi_pkg::STAT_VALID, 32'd0}
	};

	// phase settings: frames_allocated, frames_filled, loop_period, ignore_time
	logic [31:0] phases [9][4] = '{
		'{8, 8, 9000, 0}, '{8, 8, 32'hFFFF_FFFF, 0}, '{8, 8, 0, 0},
		'{100, 8, 40000, 1}, '{1, 3, 5000, 0}, '{5, 8, 70000, 0},
		'{0, 8, 100, 1}, '{8, 1, 30000, 0}, '{6, 6, 12000, 0}
	};

	initial begin
		pose_res_t r;
		logic [1:0] cmd;
		logic [3:0] ch;
		logic [31:0] value, tv;
		logic [5:0] fi;
		int pick;
		cursor = 0;
		acc_time = 0;
		alloc_reg = 0;
		filled_reg = 0;
		period_reg = 0;
		ignore_reg = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		send_burst = 1;
		// load the first slots: frames 0 and 1 share a time, 1 and 2 hold opposite extremes
		for (int f = 0; f < LOADED; f++) begin
			for (int c = 0; c <= kpi_pkg::NUM_CH; c++) begin
				if (c == kpi_pkg::NUM_CH) value = (f <= 1) ? 32'd0 : 32'((f - 1) * 1000);
				else if (f == 1) value = 32'h7FFF_FFFF;
				else if (f == 2) value = 32'h8000_0000;
				else value = $urandom;
				send_item(kpi_pkg::CMD_WRITE, 6'(f), 4'(c), value, $urandom, 1);
			end
		end
		send_burst = 0;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				write_reg(rows[i].cmd, rows[i].value);
			end else begin
				send_item(rows[i].cmd, rows[i].fi, rows[i].ch, rows[i].value, rows[i].tv,
					!rows[i].typed);
				if (rows[i].typed) begin
					for (int j = 0; j < kpi_pkg::NUM_CH; j++) begin
						r.ch = 4'(j);
						r.val = (rows[i].tstat == kpi_pkg::STAT_NULL && j >= kpi_pkg::SCALE_FIRST)
							? kpi_pkg::ONE_Q16 : rows[i].tval;
						r.last = (j == kpi_pkg::NUM_CH - 1);
						r.stat = rows[i].tstat;
						pending_poses.push_back(r);
					end
				end
			end
		end
		for (int p = 0; p < 9; p++) begin
			write_reg(kpi_pkg::REG_ALLOC, phases[p][0]);
			write_reg(kpi_pkg::REG_FILLED, phases[p][1]);
			write_reg(kpi_pkg::REG_PERIOD, phases[p][2]);
			write_reg(kpi_pkg::REG_IGNORE, phases[p][3]);
			send_burst = (p % 3 == 1);
			recv_burst = (p % 4 == 2);
			hold_for_empty = (p == 3);
			for (int k = 0; k < 24; k++) begin
				pick = $urandom_range(0, 99);
				fi = $urandom;
				value = $urandom;
				tv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 70000);
				ch = 4'($urandom_range(0, 10));
				if (pick < 30) begin
					cmd = kpi_pkg::CMD_WRITE;
					if (pick < 3) ch = 4'($urandom_range(11, 15));
					// keep times mostly ordered so brackets exist
					if (ch == kpi_pkg::CH_TIME && pick >= 6)
						value = (fi == 0) ? 32'd0 : 32'((fi - 1) * 1000 + $urandom_range(0, 999));
				end else if (pick < 62) begin
					cmd = kpi_pkg::CMD_QUERY_ABS;
				end else if (pick < 94) begin
					cmd = kpi_pkg::CMD_QUERY_ADV;
					if (pick < 90) tv = $urandom_range(0, 3000);
				end else begin
					cmd = 2'd3;
				end
				send_item(cmd, fi, ch, value, tv, 1);
			end
			hold_for_empty = 0;
		end
		@(negedge clk) s_tvalid <= 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("keyframe_pose_interpolator_core verification clean");
		else
			$display("keyframe_pose_interpolator_core verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("keyframe_pose_interpolator_core verification failed");
		$finish;
	end

endmodule

FILE: keyframe_pose_interpolator_core.f
+incdir+rtl/core
rtl/core/kpi_pkg.sv
rtl/core/kpi_ram.sv
rtl/core/kpi_div.sv
rtl/core/keyframe_pose_interpolator_core.sv
dv/tb.sv
